FILE: design/bqc_pkg.sv
// ----------------------------------------------------------------------------
// Biquad cascade package
// Shared constants and command codes for the cascaded biquad filter unit.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int CMD_W        = 2;
    localparam int COEF_W       = 32;
    localparam int FRAC_BITS    = 8;
    localparam int PROD_SHIFT   = 16;
    localparam int SUM_SHIFT    = 14;
    localparam int TAPS         = 5;
    localparam int NUM_STAGES_W = 3;
    localparam logic [NUM_STAGES_W-1:0] NUM_STAGES_RESET = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILTER = 2'd0,
        CMD_COEF   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

endpackage

FILE: design/bqc_serial_mult.sv
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Multiplies a signed operand by a signed coefficient, one coefficient bit
// per cycle, with a shift-and-add datapath one operand wide.
// ----------------------------------------------------------------------------
module bqc_serial_mult
    import bqc_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [W-1:0]   operand,
    input  logic signed [COEF_W-1:0] coef,
    output logic                  done,
    output logic signed [W+COEF_W-1:0] product
);

    localparam int CNT_W = $clog2(COEF_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [COEF_W-1:0] b_reg, b_next;
    logic signed [W-1:0] a_reg, a_next;
    logic signed [W:0] hi_reg, hi_next;
    logic [COEF_W-1:0] lo_reg, lo_next;
    logic signed [W+1:0] addend;
    logic signed [W+1:0] total;
    logic              last;

    always_comb
    begin
        last = (cnt_reg == CNT_W'(COEF_W - 1));
        if (!b_reg[0])
        begin
            addend = '0;
        end
        else if (last)
        begin
            addend = -(W+2)'(a_reg);
        end
        else
        begin
            addend = (W+2)'(a_reg);
        end
        total = {hi_reg[W], hi_reg} + addend;
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        b_next    = b_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            b_next   = coef;
            a_next   = operand;
            hi_next  = '0;
            lo_next  = '0;
        end
        else if (run_reg)
        begin
            hi_next = total[W+1:1];
            lo_next = {total[0], lo_reg[COEF_W-1:1]};
            b_next  = {1'b0, b_reg[COEF_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg  <= b_next;
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[W-1:0], lo_reg};

endmodule

FILE: design/cascaded_biquad_df1_filter_unit.sv
// ----------------------------------------------------------------------------
// Cascaded direct-form-1 biquad filter unit
// Filters samples through up to MAX_STAGES biquad stages with one shared
// bit-serial multiplier; also takes coefficient writes and history clears.
// ----------------------------------------------------------------------------
// A filter word runs, per stage, a load step, five multiply-accumulate taps on the
// shared bit-serial multiplier and a finish step, then an output step that waits
// for room in the output register. Coefficient and clear words are handled in idle.
// A new word is accepted only in the idle state, so one word is processed at a time.
// Reset clears coefficients and history at once through per-entry valid bits
// and sets the stage count to four.
module cascaded_biquad_df1_filter_unit
    import bqc_pkg::*;
#(
    parameter int MAX_STAGES     = 4,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int INTERNAL_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [CMD_W-1:0]               command,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic [$clog2(MAX_STAGES*TAPS)-1:0] coef_index,
    input  logic signed [COEF_W-1:0]       coef_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           clipped,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [NUM_STAGES_W-1:0]        cfg_data
);

    localparam int W      = INTERNAL_WIDTH;
    localparam int S      = SAMPLE_WIDTH;
    localparam int NCOEF  = MAX_STAGES * TAPS;
    localparam int CA_W   = $clog2(NCOEF);
    localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int PW     = W + COEF_W;
    localparam int TW     = PW - PROD_SHIFT;
    localparam int AW     = TW + 3;
    localparam int YW     = AW - SUM_SHIFT;
    localparam int XW     = (S + FRAC_BITS > W) ? S + FRAC_BITS : W;
    localparam int QW     = W + 1 - FRAC_BITS;
    localparam int OW     = (QW > S) ? QW : S;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_TAP  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_STAGES_W-1:0] num_stages_reg, num_stages_next;
    logic [STG_W-1:0]        stage_reg, stage_next;
    logic [STG_W-1:0]        last_stage;
    logic [CA_W-1:0]         caddr_reg, caddr_next;
    logic [2:0]              tap_reg, tap_next;
    logic                    clip_reg, clip_next;
    logic signed [W-1:0]     x_reg, x_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [S-1:0]     out_sample_reg, out_sample_next;
    logic                    out_clip_reg, out_clip_next;

    logic [COEF_W-1:0]       coef_mem [NCOEF];
    logic [NCOEF-1:0]        coef_valid_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic                    coef_rv_reg;

    logic [4*W-1:0]          hist_mem [MAX_STAGES];
    logic [MAX_STAGES-1:0]   hist_valid_reg;
    logic [4*W-1:0]          hist_rd_reg;
    logic                    hist_rv_reg;

    logic                    in_fire;
    logic                    coef_we;
    logic                    hist_we;
    logic                    clear_hist;

    logic                    mul_start;
    logic                    mul_done;
    logic signed [W-1:0]     mul_operand;
    logic signed [COEF_W-1:0] mul_coef;
    logic signed [PW-1:0]    mul_product;
    logic signed [TW-1:0]    term;

    logic signed [XW:0]      in_scaled;
    logic signed [W-1:0]     in_sat;
    logic                    in_ovf;
    logic signed [YW-1:0]    y_wide;
    logic signed [W-1:0]     y_sat;
    logic                    y_ovf;
    logic signed [W:0]       q_round;
    logic signed [OW:0]      q_ext;
    logic signed [S-1:0]     q_sat;
    logic                    q_ovf;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign clipped   = out_clip_reg;

    always_comb
    begin
        if (num_stages_reg == '0)
        begin
            last_stage = '0;
        end
        else if (32'(num_stages_reg) > MAX_STAGES)
        begin
            last_stage = STG_W'(MAX_STAGES - 1);
        end
        else
        begin
            last_stage = STG_W'(num_stages_reg - 1'b1);
        end
    end

    always_comb
    begin
        in_scaled = (XW+1)'(sample_in) <<< FRAC_BITS;
        in_ovf    = !((&in_scaled[XW:W-1]) || !(|in_scaled[XW:W-1]));
        if (in_ovf)
        begin
            in_sat = in_scaled[XW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            in_sat = in_scaled[W-1:0];
        end

        y_wide = acc_reg[AW-1:SUM_SHIFT];
        y_ovf  = !((&y_wide[YW-1:W-1]) || !(|y_wide[YW-1:W-1]));
        if (y_ovf)
        begin
            y_sat = y_wide[YW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        else
        begin
            y_sat = y_wide[W-1:0];
        end

        q_round = (W+1)'(x_reg) + (x_reg[W-1] ? (W+1)'((1 << FRAC_BITS) - 1) : '0);
        q_ext   = (OW+1)'($signed(q_round[W:FRAC_BITS]));
        q_ovf   = !((&q_ext[OW:S-1]) || !(|q_ext[OW:S-1]));
        if (q_ovf)
        begin
            q_sat = q_ext[OW] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
        end
        else
        begin
            q_sat = q_ext[S-1:0];
        end
    end

    always_comb
    begin
        mul_coef = coef_rv_reg ? coef_rd_reg : '0;
        unique case (tap_reg)
            3'd0:    mul_operand = x_reg;
            3'd1:    mul_operand = hist_rv_reg ? hist_rd_reg[W-1:0] : '0;
            3'd2:    mul_operand = hist_rv_reg ? hist_rd_reg[2*W-1:W] : '0;
            3'd3:    mul_operand = hist_rv_reg ? hist_rd_reg[3*W-1:2*W] : '0;
            3'd4:    mul_operand = hist_rv_reg ? hist_rd_reg[4*W-1:3*W] : '0;
            default: mul_operand = '0;
        endcase
        term = mul_product[PW-1:PROD_SHIFT];
    end

    bqc_serial_mult #(
        .W(W)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .operand (mul_operand),
        .coef    (mul_coef),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        state_next      = state_reg;
        num_stages_next = num_stages_reg;
        stage_next      = stage_reg;
        caddr_next      = caddr_reg;
        tap_next        = tap_reg;
        clip_next       = clip_reg;
        x_next          = x_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_clip_next   = out_clip_reg;
        mul_start       = 1'b0;
        coef_we         = 1'b0;
        hist_we         = 1'b0;
        clear_hist      = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            num_stages_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd_t'(command))
                        CMD_FILTER:
                        begin
                            x_next     = in_sat;
                            clip_next  = in_ovf;
                            stage_next = '0;
                            caddr_next = '0;
                            state_next = ST_LOAD;
                        end
                        CMD_COEF:
                        begin
                            coef_we = (32'(coef_index) < NCOEF);
                        end
                        CMD_CLEAR:
                        begin
                            clear_hist = 1'b1;
                        end
                        CMD_NONE:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                tap_next   = '0;
                acc_next   = '0;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                mul_start  = 1'b1;
                caddr_next = caddr_reg + 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (tap_reg >= 3'd3)
                    begin
                        acc_next = acc_reg - AW'(term);
                    end
                    else
                    begin
                        acc_next = acc_reg + AW'(term);
                    end
                    if (tap_reg == 3'(TAPS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        tap_next   = tap_reg + 1'b1;
                        state_next = ST_TAP;
                    end
                end
            end
            ST_FIN:
            begin
                hist_we   = 1'b1;
                x_next    = y_sat;
                clip_next = clip_reg | y_ovf;
                if (stage_reg == last_stage)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = q_sat;
                    out_clip_next   = clip_reg | q_ovf;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_stages_reg <= NUM_STAGES_RESET;
            stage_reg      <= '0;
            caddr_reg      <= '0;
            tap_reg        <= '0;
            clip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            coef_valid_reg <= '0;
            hist_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            num_stages_reg <= num_stages_next;
            stage_reg      <= stage_next;
            caddr_reg      <= caddr_next;
            tap_reg        <= tap_next;
            clip_reg       <= clip_next;
            out_valid_reg  <= out_valid_next;
            if (coef_we)
            begin
                coef_valid_reg[coef_index] <= 1'b1;
            end
            if (clear_hist)
            begin
                hist_valid_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_valid_reg[stage_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        acc_reg        <= acc_next;
        out_sample_reg <= out_sample_next;
        out_clip_reg   <= out_clip_next;
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_index] <= coef_value;
        end
        coef_rd_reg <= coef_mem[caddr_reg];
        coef_rv_reg <= coef_valid_reg[caddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[stage_reg] <= {hist_rv_reg ? hist_rd_reg[3*W-1:2*W] : {W{1'b0}},
                                    y_sat,
                                    hist_rv_reg ? hist_rd_reg[W-1:0] : {W{1'b0}},
                                    x_reg};
        end
        if (state_reg == ST_LOAD)
        begin
            hist_rd_reg <= hist_mem[stage_reg];
            hist_rv_reg <= hist_valid_reg[stage_reg];
        end
    end

endmodule
